>>> hw/rtl/fqts_pkg.sv
// Shared widths, defaults and register codes for the frame queue timestamp select block
`timescale 1ns / 1ps
package fqts_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SLOTS_DEF = 32;
  localparam int PTS_WIDTH_DEF = 48;

  // Fixed field widths
  localparam int PTS_IN_W   = 48;
  localparam int TIME_W     = 32;
  localparam int TIME_FRAC  = 16;
  localparam int DEN_W      = 31;
  localparam int SC_W       = 6;
  localparam int SLOT_OUT_W = 5;
  localparam int QCNT_OUT_W = 5;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register reset values
  localparam logic [SC_W-1:0]  SLOT_COUNT_RST = SC_W'(20);
  localparam logic [DEN_W-1:0] TIMEBASE_RST   = DEN_W'(90000);

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_SLOT_COUNT   = 1'b0,
    REG_TIMEBASE_DEN = 1'b1
  } reg_idx_t;

  // Request kind carried in the mode field
  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POLL = 1'b1
  } mode_t;

endpackage

>>> hw/rtl/fqts_in_if.sv
// Input channel: push or poll request
`timescale 1ns / 1ps
interface fqts_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [fqts_pkg::PTS_IN_W-1:0]  frame_pts;
  logic        [fqts_pkg::TIME_W-1:0]    present_time;

  modport source (output valid, mode, frame_pts, present_time, input ready);
  modport sink   (input valid, mode, frame_pts, present_time, output ready);
endinterface

>>> hw/rtl/fqts_out_if.sv
// Result channel: reported slot and queue depth
`timescale 1ns / 1ps
interface fqts_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   found;
  logic        [fqts_pkg::SLOT_OUT_W-1:0] frame_slot;
  logic signed [fqts_pkg::PTS_IN_W-1:0]   slot_pts;
  logic        [fqts_pkg::QCNT_OUT_W-1:0] queued_frames;

  modport source (output valid, found, frame_slot, slot_pts, queued_frames, input ready);
  modport sink   (input valid, found, frame_slot, slot_pts, queued_frames, output ready);
endinterface

>>> hw/rtl/fqts_pts_mem.sv
// Timestamp store: one write port, one registered read port, per-entry valid bits
`timescale 1ns / 1ps
module fqts_pts_mem #(
  parameter int DEPTH = fqts_pkg::MAX_SLOTS_DEF,
  parameter int WIDTH = fqts_pkg::PTS_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/frame_queue_timestamp_select_core.sv
// Top level: frame slot ring with timestamp store, poll scan sequencer and config port
`timescale 1ns / 1ps
// A push stores the frame timestamp at the write slot and returns its result through
// the ST_DONE state and the output register. A poll latches the time, forms the
// time * timebase_den product, then scans the queued slots, one per cycle, through
// the single read port of the timestamp store and a single signed comparator, and
// hands the result over once the last read has drained through the comparator; a
// full ring of 32 slots holds at most 31 queued. One request is in work at a time;
// the next is taken while the previous result still waits on the output. Writing
// slot_count empties the queue but keeps the stored timestamps. The store needs no
// clearing pass after reset.
module frame_queue_timestamp_select_core #(
  parameter int MAX_SLOTS = fqts_pkg::MAX_SLOTS_DEF,
  parameter int PTS_WIDTH = fqts_pkg::PTS_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fqts_in_if.sink                     in_ch,
  fqts_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fqts_pkg::APB_AW-1:0] paddr,
  input  logic [fqts_pkg::APB_DW-1:0] pwdata,
  output logic [fqts_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int PTR_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SCW    = (CNT_W > fqts_pkg::SC_W) ? CNT_W : fqts_pkg::SC_W;
  localparam int PROD_W = fqts_pkg::TIME_W + fqts_pkg::DEN_W;
  localparam int TICK_W = PROD_W - fqts_pkg::TIME_FRAC;
  localparam int CMP_W  = (PTS_WIDTH > TICK_W + 1) ? PTS_WIDTH : TICK_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                               state_r;
  logic [fqts_pkg::SC_W-1:0]            slot_count_r;
  logic [fqts_pkg::DEN_W-1:0]           den_r;
  logic [PTR_W-1:0]                     rd_ptr_r;
  logic [PTR_W-1:0]                     wr_ptr_r;
  logic [fqts_pkg::TIME_W-1:0]          time_r;
  logic [PROD_W-1:0]                    prod_r;
  logic [PTR_W-1:0]                     scan_idx_r;
  logic [PTR_W-1:0]                     issue_cnt_r;
  logic [PTR_W-1:0]                     scan_len_r;
  logic                                 pend_r;
  logic [PTR_W-1:0]                     pend_idx_r;
  logic                                 res_found_r;
  logic [PTR_W-1:0]                     res_slot_r;
  logic signed [PTS_WIDTH-1:0]          res_pts_r;
  logic                                 out_valid_r;
  logic                                 out_found_r;
  logic [fqts_pkg::SLOT_OUT_W-1:0]      out_slot_r;
  logic signed [fqts_pkg::PTS_IN_W-1:0] out_pts_r;
  logic [fqts_pkg::QCNT_OUT_W-1:0]      out_qcnt_r;

  logic                        in_acc;
  logic                        cfg_wr;
  logic [SCW-1:0]              sc_ext;
  logic [CNT_W-1:0]            ring_n;
  logic [CNT_W-1:0]            queued;
  logic [CNT_W-1:0]            idx_inc;
  logic [PTR_W-1:0]            idx_next;
  logic [CNT_W-1:0]            wr_inc;
  logic [PTR_W-1:0]            wr_next;
  logic signed [PTS_WIDTH-1:0] push_pts;
  logic                        mem_rd_en;
  logic [PTS_WIDTH-1:0]        mem_rd_data;
  logic signed [CMP_W-1:0]     cmp_pts;
  logic signed [CMP_W-1:0]     cmp_ticks;
  logic                        cmp_lt;
  logic                        scan_end;
  logic                        out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);

  // ring size, clamped to 2..MAX_SLOTS
  always_comb begin
    sc_ext = SCW'(slot_count_r);
    if (sc_ext < SCW'(2)) begin
      ring_n = CNT_W'(2);
    end else if (sc_ext > SCW'(MAX_SLOTS)) begin
      ring_n = CNT_W'(MAX_SLOTS);
    end else begin
      ring_n = CNT_W'(sc_ext);
    end
  end

  // (write - read) mod n; both pointers stay below n
  always_comb begin
    if (wr_ptr_r >= rd_ptr_r) begin
      queued = CNT_W'(wr_ptr_r) - CNT_W'(rd_ptr_r);
    end else begin
      queued = (ring_n - CNT_W'(rd_ptr_r)) + CNT_W'(wr_ptr_r);
    end
  end

  assign idx_inc  = CNT_W'(scan_idx_r) + CNT_W'(1);
  assign idx_next = (idx_inc == ring_n) ? '0 : PTR_W'(idx_inc);
  assign wr_inc   = CNT_W'(wr_ptr_r) + CNT_W'(1);
  assign wr_next  = (wr_inc == ring_n) ? '0 : PTR_W'(wr_inc);

  assign push_pts = PTS_WIDTH'(in_ch.frame_pts);

  assign mem_rd_en = (state_r == ST_SCAN) && (issue_cnt_r != scan_len_r);

  fqts_pts_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (PTS_WIDTH),
    .AW    (PTR_W)
  ) u_pts_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && (in_ch.mode == fqts_pkg::MODE_PUSH)),
    .wr_addr (wr_ptr_r),
    .wr_data (push_pts),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (mem_rd_data)
  );

  // shared comparator: stored timestamp against ticks, signed
  assign cmp_pts   = CMP_W'(signed'(mem_rd_data));
  assign cmp_ticks = signed'(CMP_W'(prod_r[PROD_W-1:fqts_pkg::TIME_FRAC]));
  assign cmp_lt    = (cmp_pts < cmp_ticks);

  assign scan_end = (issue_cnt_r == scan_len_r) && !pend_r;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_count_r <= fqts_pkg::SLOT_COUNT_RST;
      den_r        <= fqts_pkg::TIMEBASE_RST;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (fqts_pkg::reg_idx_t'(paddr[2]))
          fqts_pkg::REG_SLOT_COUNT: begin
            slot_count_r <= pwdata[fqts_pkg::SC_W-1:0];
            rd_ptr_r     <= '0;
            wr_ptr_r     <= '0;
          end
          fqts_pkg::REG_TIMEBASE_DEN: begin
            den_r <= pwdata[fqts_pkg::DEN_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.mode == fqts_pkg::MODE_PUSH) begin
              wr_ptr_r <= wr_next;
              state_r  <= ST_DONE;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          pend_r <= mem_rd_en;
          if (scan_end) begin
            if (res_found_r) begin
              rd_ptr_r <= res_slot_r;
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath and scan bookkeeping
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        time_r <= in_ch.present_time;
        if (in_ch.mode == fqts_pkg::MODE_PUSH) begin
          res_found_r <= 1'b1;
          res_slot_r  <= wr_ptr_r;
          res_pts_r   <= push_pts;
        end else begin
          res_found_r <= 1'b0;
          res_slot_r  <= '0;
          res_pts_r   <= '0;
        end
      end
      ST_MUL: begin
        prod_r      <= PROD_W'(time_r) * PROD_W'(den_r);
        scan_idx_r  <= rd_ptr_r;
        issue_cnt_r <= '0;
        scan_len_r  <= PTR_W'(queued);
      end
      ST_SCAN: begin
        if (mem_rd_en) begin
          scan_idx_r  <= idx_next;
          issue_cnt_r <= issue_cnt_r + PTR_W'(1);
          pend_idx_r  <= scan_idx_r;
        end
        // last qualifying slot wins
        if (pend_r && cmp_lt) begin
          res_found_r <= 1'b1;
          res_slot_r  <= pend_idx_r;
          res_pts_r   <= signed'(mem_rd_data);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found_r;
      out_slot_r  <= fqts_pkg::SLOT_OUT_W'(res_slot_r);
      out_pts_r   <= fqts_pkg::PTS_IN_W'(res_pts_r);
      out_qcnt_r  <= fqts_pkg::QCNT_OUT_W'(queued);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.frame_slot    = out_slot_r;
  assign out_ch.slot_pts      = out_pts_r;
  assign out_ch.queued_frames = out_qcnt_r;

  always_comb begin
    case (fqts_pkg::reg_idx_t'(paddr[2]))
      fqts_pkg::REG_SLOT_COUNT:   prdata = fqts_pkg::APB_DW'(slot_count_r);
      fqts_pkg::REG_TIMEBASE_DEN: prdata = fqts_pkg::APB_DW'(den_r);
      default:                    prdata = '0;
    endcase
  end

endmodule
